/* hdl/ost_pkg.sv */
// shared types and codes for the ordered integer set table
// used by ost_front, ost_back and the top level
package ost_pkg;

    localparam logic [2:0] CMD_INSERT  = 3'd0;
    localparam logic [2:0] CMD_DELETE  = 3'd1;
    localparam logic [2:0] CMD_MEMBER  = 3'd2;
    localparam logic [2:0] CMD_ORDINAL = 3'd3;
    localparam logic [2:0] CMD_ELEMENT = 3'd4;
    localparam logic [2:0] CMD_CLEAR   = 3'd5;
    localparam logic [2:0] CMD_SORT    = 3'd6;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_PRESENT = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;
    localparam logic [1:0] STAT_MISSING = 2'd3;

    typedef enum logic [2:0] {
        OP_INSERT,
        OP_DELETE,
        OP_MEMBER,
        OP_ORDINAL,
        OP_ELEMENT,
        OP_CLEAR,
        OP_SORT,
        OP_BAD
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] value;
        logic [5:0]  position;
    } item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHUP_RD,
        ST_SHUP_WR,
        ST_SHDN_RD,
        ST_SHDN_WR,
        ST_ELEM_RD,
        ST_ELEM_Q,
        ST_SORT_I,
        ST_SORT_IQ,
        ST_SORT_JRD,
        ST_SORT_JCMP,
        ST_SORT_SW1,
        ST_SORT_SW2,
        ST_DONE
    } bstate_t;

endpackage

/* hdl/ordered_integer_set_table.sv */
// top level of the ordered integer set table: front queue plus back sequencer
// depends on ost_pkg, ost_front, ost_back (and ost_ram below it)
//
//  channel | handshake           | payload
//  --------+---------------------+--------------------------------------------
//  in      | in_valid / in_stall | cmd, value, position
//  out     | out_valid/out_stall | status, found, read_value, ordinal_pos, count
//
// one item at a time in the back end; each leaves the queue, then runs a search (insert,
//   delete, member, ordinal) with a shift when an insert adds or a delete removes an entry,
//   an element read or a sort, and then loads the result register; clear and unknown
//   commands go straight to that load
// reset clears count and handshake state; ram contents are left as they are
// a finished item waits while the result register is full and stalled; the two entry
// front queue keeps accepting items meanwhile and stalls its input once both are taken
module ordered_integer_set_table
    import ost_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  cmd,
    input  logic signed [31:0] value,
    input  logic [5:0]  position,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        found,
    output logic signed [31:0] read_value,
    output logic [6:0]  ordinal_pos,
    output logic [6:0]  count
);

    logic  q_valid;
    logic  q_pop;
    item_t q_item;
    logic [31:0] rd_bits;

    ost_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .value    (value),
        .position (position),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    ost_back #(.CAPACITY(CAPACITY)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .found       (found),
        .read_value  (rd_bits),
        .ordinal_pos (ordinal_pos),
        .count       (count)
    );

    assign read_value = $signed(rd_bits);

endmodule

/* hdl/ost_ram.sv */
// generic single write port ram with one registered read port
// no dependencies
module ost_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/ost_front.sv */
// front end: accepts items, decodes the command, holds them in a two entry queue
// depends on ost_pkg
module ost_front
    import ost_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  cmd,
    input  logic [31:0] value,
    input  logic [5:0]  position,
    output logic        q_valid,
    output item_t       q_item,
    input  logic        q_pop
);

    item_t       slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;
    logic        push;
    op_t         op_dec;

    always_comb
    begin
        unique case (cmd)
            CMD_INSERT:  op_dec = OP_INSERT;
            CMD_DELETE:  op_dec = OP_DELETE;
            CMD_MEMBER:  op_dec = OP_MEMBER;
            CMD_ORDINAL: op_dec = OP_ORDINAL;
            CMD_ELEMENT: op_dec = OP_ELEMENT;
            CMD_CLEAR:   op_dec = OP_CLEAR;
            CMD_SORT:    op_dec = OP_SORT;
            default:     op_dec = OP_BAD;
        endcase
    end

    assign in_stall = (fill_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (fill_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= '{op: op_dec, value: value, position: position};
        end
    end

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> fill_reg != 2'd0)
        else $error("queue popped while empty");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != 2'd3)
        else $error("queue fill out of range");

endmodule

/* hdl/ost_back.sv */
// back end: sequencer that runs each item against the element ram
// depends on ost_pkg and ost_ram
module ost_back
    import ost_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        found,
    output logic [31:0] read_value,
    output logic [6:0]  ordinal_pos,
    output logic [6:0]  count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 6) ? CW : 6;

    bstate_t          state_reg, state_next;
    item_t            cur_reg, cur_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    scan_reg, scan_next;
    logic [CW-1:0]    cmp_reg, cmp_next;
    logic             dv_reg, dv_next;
    logic [CW-1:0]    ptr_reg, ptr_next;
    logic [CW-1:0]    jdx_reg, jdx_next;
    logic [CW-1:0]    m_reg, m_next;
    logic [31:0]      mv_reg, mv_next;
    logic [31:0]      iv_reg, iv_next;
    logic [1:0]       res_status_reg, res_status_next;
    logic             res_found_reg, res_found_next;
    logic [31:0]      res_rd_reg, res_rd_next;
    logic [CW-1:0]    res_ord_reg, res_ord_next;
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       out_status_reg, out_status_next;
    logic             out_found_reg, out_found_next;
    logic [31:0]      out_rd_reg, out_rd_next;
    logic [6:0]       out_ord_reg, out_ord_next;
    logic [6:0]       out_count_reg, out_count_next;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [31:0]      ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [31:0]      ram_q;

    logic             issue, hit, search_done, pos_ok, out_free;
    logic [CW-1:0]    ptr_inc;

    ost_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    assign issue       = scan_reg < count_reg;
    assign hit         = dv_reg && (ram_q == cur_reg.value);
    assign search_done = hit || !issue;
    assign ptr_inc     = ptr_reg + 1'b1;
    assign pos_ok      = PW'(cur_reg.position) < PW'(count_reg);
    assign out_free    = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_item.op) inside
                        OP_INSERT, OP_DELETE, OP_MEMBER, OP_ORDINAL: state_next = ST_SEARCH;
                        OP_ELEMENT: state_next = ST_ELEM_RD;
                        OP_SORT:    state_next = ST_SORT_I;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_SEARCH:
            begin
                if (search_done)
                begin
                    if (cur_reg.op == OP_INSERT && !hit && count_reg < CW'(CAPACITY))
                    begin
                        state_next = ST_SHUP_RD;
                    end
                    else if (cur_reg.op == OP_DELETE && hit)
                    begin
                        state_next = ST_SHDN_RD;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SHUP_RD:   state_next = (ptr_reg == '0) ? ST_DONE : ST_SHUP_WR;
            ST_SHUP_WR:   state_next = ST_SHUP_RD;
            ST_SHDN_RD:   state_next = (ptr_inc >= count_reg) ? ST_DONE : ST_SHDN_WR;
            ST_SHDN_WR:   state_next = ST_SHDN_RD;
            ST_ELEM_RD:   state_next = pos_ok ? ST_ELEM_Q : ST_DONE;
            ST_ELEM_Q:    state_next = ST_DONE;
            ST_SORT_I:    state_next = (ptr_inc >= count_reg) ? ST_DONE : ST_SORT_IQ;
            ST_SORT_IQ:   state_next = ST_SORT_JRD;
            ST_SORT_JRD:  state_next = (jdx_reg >= count_reg) ? ST_SORT_SW1 : ST_SORT_JCMP;
            ST_SORT_JCMP: state_next = ST_SORT_JRD;
            ST_SORT_SW1:  state_next = ST_SORT_SW2;
            ST_SORT_SW2:  state_next = ST_SORT_I;
            ST_DONE:      state_next = out_free ? ST_IDLE : ST_DONE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cur_next        = cur_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        cmp_next        = cmp_reg;
        dv_next         = 1'b0;
        ptr_next        = ptr_reg;
        jdx_next        = jdx_reg;
        m_next          = m_reg;
        mv_next         = mv_reg;
        iv_next         = iv_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_rd_next     = res_rd_reg;
        res_ord_next    = res_ord_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_rd_next     = out_rd_reg;
        out_ord_next    = out_ord_reg;
        out_count_next  = out_count_reg;
        q_pop           = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = ptr_reg[AW-1:0];
        ram_wdata       = ram_q;
        ram_raddr       = ptr_reg[AW-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop           = 1'b1;
                    cur_next        = q_item;
                    scan_next       = '0;
                    ptr_next        = '0;
                    res_status_next = (q_item.op == OP_BAD) ? STAT_MISSING : STAT_OK;
                    res_found_next  = 1'b0;
                    res_rd_next     = '0;
                    res_ord_next    = '0;
                    if (q_item.op == OP_CLEAR)
                    begin
                        count_next = '0;
                    end
                end
            end
            ST_SEARCH:
            begin
                // read one entry ahead while comparing the previous one
                if (issue && !hit)
                begin
                    ram_raddr = scan_reg[AW-1:0];
                    scan_next = scan_reg + 1'b1;
                    cmp_next  = scan_reg;
                    dv_next   = 1'b1;
                end
                if (search_done)
                begin
                    unique case (cur_reg.op)
                        OP_INSERT:
                        begin
                            if (hit)
                            begin
                                res_status_next = STAT_PRESENT;
                            end
                            else if (count_reg >= CW'(CAPACITY))
                            begin
                                res_status_next = STAT_FULL;
                            end
                            ptr_next = count_reg;
                        end
                        OP_DELETE:
                        begin
                            if (!hit)
                            begin
                                res_status_next = STAT_MISSING;
                            end
                            ptr_next = cmp_reg;
                        end
                        OP_MEMBER:
                        begin
                            res_found_next = hit;
                        end
                        default:
                        begin
                            if (hit)
                            begin
                                res_ord_next = cmp_reg + 1'b1;
                            end
                            else
                            begin
                                res_status_next = STAT_MISSING;
                            end
                        end
                    endcase
                end
            end
            ST_SHUP_RD:
            begin
                if (ptr_reg == '0)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = '0;
                    ram_wdata  = cur_reg.value;
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    ram_raddr = AW'(ptr_reg - 1'b1);
                end
            end
            ST_SHUP_WR:
            begin
                ram_we   = 1'b1;
                ptr_next = ptr_reg - 1'b1;
            end
            ST_SHDN_RD:
            begin
                if (ptr_inc >= count_reg)
                begin
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    ram_raddr = ptr_inc[AW-1:0];
                end
            end
            ST_SHDN_WR:
            begin
                ram_we   = 1'b1;
                ptr_next = ptr_inc;
            end
            ST_ELEM_RD:
            begin
                ram_raddr = AW'(cur_reg.position);
                if (!pos_ok)
                begin
                    res_status_next = STAT_MISSING;
                end
            end
            ST_ELEM_Q:
            begin
                res_rd_next = ram_q;
            end
            ST_SORT_I:
            begin
                ram_raddr = ptr_reg[AW-1:0];
            end
            ST_SORT_IQ:
            begin
                mv_next  = ram_q;
                iv_next  = ram_q;
                m_next   = ptr_reg;
                jdx_next = ptr_inc;
            end
            ST_SORT_JRD:
            begin
                ram_raddr = jdx_reg[AW-1:0];
            end
            ST_SORT_JCMP:
            begin
                if ($signed(ram_q) < $signed(mv_reg))
                begin
                    mv_next = ram_q;
                    m_next  = jdx_reg;
                end
                jdx_next = jdx_reg + 1'b1;
            end
            ST_SORT_SW1:
            begin
                ram_we    = 1'b1;
                ram_waddr = m_reg[AW-1:0];
                ram_wdata = iv_reg;
            end
            ST_SORT_SW2:
            begin
                ram_we    = 1'b1;
                ram_wdata = mv_reg;
                ptr_next  = ptr_inc;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_found_next  = res_found_reg;
                    out_rd_next     = res_rd_reg;
                    out_ord_next    = 7'(res_ord_reg);
                    out_count_next  = 7'(count_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            dv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dv_reg        <= dv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        scan_reg       <= scan_next;
        cmp_reg        <= cmp_next;
        ptr_reg        <= ptr_next;
        jdx_reg        <= jdx_next;
        m_reg          <= m_next;
        mv_reg         <= mv_next;
        iv_reg         <= iv_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_rd_reg     <= res_rd_next;
        res_ord_reg    <= res_ord_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
        out_rd_reg     <= out_rd_next;
        out_ord_reg    <= out_ord_next;
        out_count_reg  <= out_count_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign found       = out_found_reg;
    assign read_value  = out_rd_reg;
    assign ordinal_pos = out_ord_reg;
    assign count       = out_count_reg;

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH && dv_reg) |-> cmp_reg < count_reg)
        else $error("compared entry beyond count");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == ST_IDLE && q_valid))
        else $error("item taken while busy");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE && state_reg != ST_SHUP_RD && state_reg != ST_SHDN_RD)
        |=> $stable(count_reg))
        else $error("count changed outside an update state");

endmodule
